>>> rtl/core/psc_pkg.sv
// Shared constants, types and helpers for the pressure sensor compensation block.
package psc_pkg;

    localparam int DW       = 32;   // datapath word
    localparam int DIV_TAG_W = 58;  // sideband carried through a divider
    localparam int DIV_STEPS = 32;  // one quotient bit per stage

    // register indexes of the configuration port
    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic [31:0] K_B6_OFS   = 32'd4000;
    localparam logic [31:0] K_B4_OFS   = 32'd32768;
    localparam logic [31:0] K_B7_SCALE = 32'd50000;
    localparam logic [31:0] K_P_C1     = 32'd3038;
    localparam logic [31:0] K_P_C2     = 32'hFFFF_E343; // -7357
    localparam logic [31:0] K_P_C3     = 32'd3791;

    typedef logic [DW-1:0] t_word;

    function automatic t_word sx16(input logic [15:0] h);
        sx16 = {{16{h[15]}}, h};
    endfunction

endpackage

>>> rtl/core/pressure_sensor_compensation.sv
// Top level: barometric sensor temperature and pressure compensation pipeline.
//
//  channel  | dir | tdata (low bit up)                      | tuser (low bit up)
//  s        | in  | raw_temperature 16, raw_pressure 24     | -
//  m        | out | temperature_tenths 16, pressure_pa 20,  | divide_fault, clipped
//           |     | 4 zero bits                             |
//  cfg      | in  | write enable, index 3 bits, data 32     | -
//
// One item per cycle while the output is not stalled; two 32-stage dividers
// (temperature and pressure) plus 13 arithmetic stages around them.
// Synchronous active-low reset clears all valid bits and the configuration registers; OSS resets to 3.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module pressure_sensor_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // raw_temperature[15:0], raw_pressure[39:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // temperature_tenths[15:0], pressure_pa[35:16], zeros
    output logic [1:0]  o_m_tuser,   // divide_fault[0], clipped[1]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    import psc_pkg::*;

    // configuration registers
    t_word      r_ac12, r_ac34, r_ac56, r_b12, r_mcmd;
    logic [1:0] r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac12 <= '0; r_ac34 <= '0; r_ac56 <= '0;
            r_b12  <= '0; r_mcmd <= '0; r_oss  <= 2'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AC1_AC2: r_ac12 <= i_cfg_wdata;
                REG_AC3_AC4: r_ac34 <= i_cfg_wdata;
                REG_AC5_AC6: r_ac56 <= i_cfg_wdata;
                REG_B1_B2:   r_b12  <= i_cfg_wdata;
                REG_MC_MD:   r_mcmd <= i_cfg_wdata;
                REG_OSS:     r_oss  <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    t_word ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx16(r_ac12[31:16]);
    assign ac2 = sx16(r_ac12[15:0]);
    assign ac3 = sx16(r_ac34[31:16]);
    assign ac4 = {16'd0, r_ac34[15:0]};
    assign ac5 = {16'd0, r_ac56[31:16]};
    assign ac6 = {16'd0, r_ac56[15:0]};
    assign b1  = sx16(r_b12[31:16]);
    assign b2  = sx16(r_b12[15:0]);
    assign mc  = sx16(r_mcmd[31:16]);
    assign md  = sx16(r_mcmd[15:0]);

    // global advance: move when the output register is free or being taken
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // ---------------- valid chain outside the dividers ----------------
    logic r_v1, r_v2, r_vt, r_vp1, r_vp2, r_vp3, r_vp4, r_vp5, r_vp6;
    logic r_vq1, r_vq2, r_vq3, r_vo;
    logic d1_v, d2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_vt <= 1'b0;
            r_vp1 <= 1'b0; r_vp2 <= 1'b0; r_vp3 <= 1'b0;
            r_vp4 <= 1'b0; r_vp5 <= 1'b0; r_vp6 <= 1'b0;
            r_vq1 <= 1'b0; r_vq2 <= 1'b0; r_vq3 <= 1'b0; r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid; r_v2 <= r_v1; r_vt <= d1_v;
            r_vp1 <= r_vt; r_vp2 <= r_vp1; r_vp3 <= r_vp2;
            r_vp4 <= r_vp3; r_vp5 <= r_vp4; r_vp6 <= r_vp5;
            r_vq1 <= d2_v; r_vq2 <= r_vq1; r_vq3 <= r_vq2; r_vo <= r_vq3;
        end
    end

    // ---------------- stage 1: raw temperature product ----------------
    t_word       r1_prod;
    logic [23:0] r1_up;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= DW'(({16'd0, i_s_tdata[15:0]} - ac6) * ac5);
            r1_up   <= 24'({8'd0, i_s_tdata[39:16]} >> (4'd8 - {2'd0, r_oss}));
        end
    end

    // ---------------- stage 2: X1 and temperature divisor ----------------
    t_word       r2_x1, r2_den;
    logic [23:0] r2_up;
    t_word       x1_s2;
    assign x1_s2 = DW'($signed(r1_prod) >>> 15);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x1  <= x1_s2;
            r2_den <= x1_s2 + md;
            r2_up  <= r1_up;
        end
    end

    // signed division MC<<11 / den through magnitudes
    t_word                d1_n, d1_mag_n, d1_mag_d, d1_q;
    logic                 d1_zero, d1_neg;
    logic [DIV_TAG_W-1:0] d1_tag_in, d1_tag;
    assign d1_n      = mc << 11;
    assign d1_zero   = (r2_den == '0);
    assign d1_neg    = d1_n[DW-1] ^ r2_den[DW-1];
    assign d1_mag_n  = d1_n[DW-1] ? (32'd0 - d1_n) : d1_n;
    assign d1_mag_d  = d1_zero ? 32'd1 : (r2_den[DW-1] ? (32'd0 - r2_den) : r2_den);
    assign d1_tag_in = {d1_zero, d1_neg, r2_up, r2_x1};

    psc_div u_div_t (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_v(r_v2),
        .i_num(d1_mag_n), .i_den(d1_mag_d), .i_tag(d1_tag_in),
        .o_v(d1_v), .o_quo(d1_q), .o_tag(d1_tag)
    );

    // ---------------- B5 ----------------
    t_word       rt_b5;
    logic [23:0] rt_up;
    logic        rt_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rt_b5  <= d1_tag[31:0] + (d1_tag[56] ? (32'd0 - d1_q) : d1_q);
            rt_up  <= d1_tag[55:32];
            rt_flt <= d1_tag[57];
        end
    end

    // ---------------- P1: temperature and B6 ----------------
    t_word       rp1_t, rp1_b6;
    logic [23:0] rp1_up;
    logic        rp1_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rp1_t   <= DW'($signed(rt_b5 + 32'd8) >>> 4);
            rp1_b6  <= rt_b5 - K_B6_OFS;
            rp1_up  <= rt_up;
            rp1_flt <= rt_flt;
        end
    end

    // ---------------- P2: B6 products ----------------
    t_word       rp2_t, rp2_sqp, rp2_m2, rp2_m3;
    logic [23:0] rp2_up;
    logic        rp2_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rp2_sqp <= DW'(rp1_b6 * rp1_b6);
            rp2_m2  <= DW'(ac2 * rp1_b6);
            rp2_m3  <= DW'(ac3 * rp1_b6);
            rp2_t   <= rp1_t;
            rp2_up  <= rp1_up;
            rp2_flt <= rp1_flt;
        end
    end

    // ---------------- P3: B1/B2 products of the square ----------------
    t_word       rp3_t, rp3_pb1, rp3_pb2, rp3_m2, rp3_m3, sq;
    logic [23:0] rp3_up;
    logic        rp3_flt;
    assign sq = DW'($signed(rp2_sqp) >>> 12);
    always_ff @(posedge i_clk) begin
        if (en) begin
            rp3_pb1 <= DW'(b1 * sq);
            rp3_pb2 <= DW'(b2 * sq);
            rp3_m2  <= rp2_m2;
            rp3_m3  <= rp2_m3;
            rp3_t   <= rp2_t;
            rp3_up  <= rp2_up;
            rp3_flt <= rp2_flt;
        end
    end

    // ---------------- P4: B3 and X3 for B4 ----------------
    t_word       rp4_t, rp4_b3, rp4_x3, x3a, x3b;
    logic [23:0] rp4_up;
    logic        rp4_flt;
    assign x3a = DW'($signed(rp3_pb2) >>> 11) + DW'($signed(rp3_m2) >>> 11);
    assign x3b = DW'($signed(rp3_m3) >>> 13) + DW'($signed(rp3_pb1) >>> 16) + 32'd2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rp4_b3  <= DW'($signed((((ac1 << 2) + x3a) << r_oss) + 32'd2) >>> 2);
            rp4_x3  <= DW'($signed(x3b) >>> 2);
            rp4_t   <= rp3_t;
            rp4_up  <= rp3_up;
            rp4_flt <= rp3_flt;
        end
    end

    // ---------------- P5: B4 product, UP - B3 ----------------
    t_word rp5_t, rp5_b4p, rp5_diff;
    logic  rp5_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rp5_b4p  <= DW'(ac4 * (rp4_x3 + K_B4_OFS));
            rp5_diff <= {8'd0, rp4_up} - rp4_b3;
            rp5_t    <= rp4_t;
            rp5_flt  <= rp4_flt;
        end
    end

    // ---------------- P6: B4 and B7 ----------------
    t_word rp6_t, rp6_b4, rp6_b7;
    logic  rp6_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rp6_b4  <= rp5_b4p >> 15;
            rp6_b7  <= DW'(rp5_diff * (K_B7_SCALE >> r_oss));
            rp6_t   <= rp5_t;
            rp6_flt <= rp5_flt;
        end
    end

    // unsigned pressure division
    logic                 d2_zero, d2_big;
    t_word                d2_n, d2_d, d2_q;
    logic [DIV_TAG_W-1:0] d2_tag_in, d2_tag;
    assign d2_zero   = (rp6_b4 == '0);
    assign d2_big    = rp6_b7[DW-1];
    assign d2_n      = d2_big ? rp6_b7 : (rp6_b7 << 1);
    assign d2_d      = d2_zero ? 32'd1 : rp6_b4;
    assign d2_tag_in = {24'd0, rp6_flt | d2_zero, d2_big, rp6_t};

    psc_div u_div_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_v(r_vp6),
        .i_num(d2_n), .i_den(d2_d), .i_tag(d2_tag_in),
        .o_v(d2_v), .o_quo(d2_q), .o_tag(d2_tag)
    );

    // ---------------- Q1: pressure before the polynomial ----------------
    t_word rq1_p, rq1_t;
    logic  rq1_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rq1_p   <= d2_tag[32] ? (d2_q << 1) : d2_q;
            rq1_t   <= d2_tag[31:0];
            rq1_flt <= d2_tag[33];
        end
    end

    // ---------------- Q2: square and linear terms ----------------
    t_word rq2_p, rq2_t, rq2_sq, rq2_lin, px;
    logic  rq2_flt;
    assign px = DW'($signed(rq1_p) >>> 8);
    always_ff @(posedge i_clk) begin
        if (en) begin
            rq2_sq  <= DW'(px * px);
            rq2_lin <= DW'(K_P_C2 * rq1_p);
            rq2_p   <= rq1_p;
            rq2_t   <= rq1_t;
            rq2_flt <= rq1_flt;
        end
    end

    // ---------------- Q3: scaled square ----------------
    t_word rq3_p, rq3_t, rq3_sq, rq3_lin;
    logic  rq3_flt;
    always_ff @(posedge i_clk) begin
        if (en) begin
            rq3_sq  <= DW'(rq2_sq * K_P_C1);
            rq3_lin <= rq2_lin;
            rq3_p   <= rq2_p;
            rq3_t   <= rq2_t;
            rq3_flt <= rq2_flt;
        end
    end

    // ---------------- output: final pressure, saturation ----------------
    t_word       pf, corr;
    logic        t_hi, t_lo, p_hi, p_lo;
    logic [15:0] n_temp;
    logic [19:0] n_pres;
    assign corr = DW'($signed(rq3_sq) >>> 16) + DW'($signed(rq3_lin) >>> 16) + K_P_C3;
    assign pf   = rq3_p + DW'($signed(corr) >>> 4);
    assign t_hi = $signed(rq3_t) > $signed(32'sd32767);
    assign t_lo = $signed(rq3_t) < $signed(-32'sd32768);
    assign p_hi = $signed(pf) > $signed(32'sd1048575);
    assign p_lo = pf[DW-1];
    assign n_temp = t_hi ? 16'h7FFF : (t_lo ? 16'h8000 : rq3_t[15:0]);
    assign n_pres = p_hi ? 20'hFFFFF : (p_lo ? 20'd0 : pf[19:0]);

    logic [15:0] r_temp;
    logic [19:0] r_pres;
    logic        r_flt, r_clip;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp <= rq3_flt ? 16'd0 : n_temp;
            r_pres <= rq3_flt ? 20'd0 : n_pres;
            r_flt  <= rq3_flt;
            r_clip <= !rq3_flt && (t_hi || t_lo || p_hi || p_lo);
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {4'd0, r_pres, r_temp};
    assign o_m_tuser  = {r_clip, r_flt};

    // ---------------- checks ----------------
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 40'd0))
        else $error("fault item carries nonzero results");
    a_fault_noclip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("fault and clip both set");
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while pipeline is frozen");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

>>> rtl/core/psc_div.sv
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
module psc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_v,
    input  psc_pkg::t_word                i_num,
    input  psc_pkg::t_word                i_den,
    input  logic [psc_pkg::DIV_TAG_W-1:0] i_tag,
    output logic                          o_v,
    output psc_pkg::t_word                o_quo,
    output logic [psc_pkg::DIV_TAG_W-1:0] o_tag
);
    import psc_pkg::*;

    logic                 r_v   [DIV_STEPS];
    t_word                r_rem [DIV_STEPS];
    t_word                r_num [DIV_STEPS];
    t_word                r_den [DIV_STEPS];
    t_word                r_quo [DIV_STEPS];
    logic [DIV_TAG_W-1:0] r_tag [DIV_STEPS];

    t_word                n_rem [DIV_STEPS];
    logic                 n_bit [DIV_STEPS];

    // one compare/subtract per stage; the first stage works on the input
    always_comb begin
        logic [DW:0] trial;
        trial = {{DW{1'b0}}, i_num[DW-1]};
        if (trial >= {1'b0, i_den}) begin
            n_rem[0] = DW'(trial - {1'b0, i_den});
            n_bit[0] = 1'b1;
        end else begin
            n_rem[0] = trial[DW-1:0];
            n_bit[0] = 1'b0;
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            trial = {r_rem[k-1], r_num[k-1][DW-1]};
            if (trial >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = DW'(trial - {1'b0, r_den[k-1]});
                n_bit[k] = 1'b1;
            end else begin
                n_rem[k] = trial[DW-1:0];
                n_bit[k] = 1'b0;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_v;
            for (int k = 1; k < DIV_STEPS; k++) r_v[k] <= r_v[k-1];
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_num[0] <= {i_num[DW-2:0], 1'b0};
            r_den[0] <= i_den;
            r_quo[0] <= {{(DW-1){1'b0}}, n_bit[0]};
            r_tag[0] <= i_tag;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= {r_num[k-1][DW-2:0], 1'b0};
                r_den[k] <= r_den[k-1];
                r_quo[k] <= {r_quo[k-1][DW-2:0], n_bit[k]};
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_v   = r_v[DIV_STEPS-1];
    assign o_quo = r_quo[DIV_STEPS-1];
    assign o_tag = r_tag[DIV_STEPS-1];

endmodule
